/* rtl/sphck_pkg.sv */
// Shared constants, types and helpers for the 2D cubic spline kernel block.
package sphck_pkg;

    // APB register map: word index taken from paddr[2]
    localparam int          APB_ADDR_W     = 3;
    localparam logic [0:0]  REG_SMOOTH_LEN = 1'b0;
    localparam logic [15:0] H_RESET        = 16'd4096;   // 1.0 in Q4.12

    localparam logic [31:0] ALPHA_Q32      = 32'd2929565467;  // 15/(7*pi), Q0.32
    localparam logic [29:0] TWO_THIRDS_Q30 = 30'd715827883;
    localparam logic [31:0] TWO_Q30        = 32'h8000_0000;   // 2.0 in Q2.30
    localparam logic [31:0] RECIP3_Q33     = 32'hAAAA_AAAB;   // ceil(2^33/3)

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } t_grad;

    typedef struct packed {
        logic [31:0] kernel_value;
        logic [31:0] gradient_x;
        logic [31:0] gradient_y;
        logic        in_support;
        logic        saturated;
    } t_result;

    // Signed Q16.16 from a magnitude quotient; ovf means quotient >= 2^32.
    function automatic t_grad sat_grad(input logic [31:0] quot, input logic ovf,
                                       input logic neg, input logic zero);
        t_grad res;
        logic  big;
        res = '0;
        big = 1'b0;
        if (zero) begin
            res = '0;
        end else if (neg) begin
            big       = ovf || (quot > 32'h8000_0000);
            res.value = big ? 32'h8000_0000 : 32'(~quot + 32'd1);
            res.sat   = big;
        end else begin
            big       = ovf || quot[31];
            res.value = big ? 32'h7FFF_FFFF : quot;
            res.sat   = big;
        end
        return res;
    endfunction

endpackage

/* rtl/sphck_in_if.sv */
// Input channel: one particle pair per transaction.
interface sphck_in_if #(
    parameter int COORD_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic        [COORD_WIDTH-1:0] distance;
    logic signed [COORD_WIDTH-1:0] offset_x;
    logic signed [COORD_WIDTH-1:0] offset_y;

    modport source (output valid, distance, offset_x, offset_y, input ready);
    modport sink   (input valid, distance, offset_x, offset_y, output ready);
endinterface

/* rtl/sphck_out_if.sv */
// Output channel: kernel value, gradient and flags per transaction.
interface sphck_out_if ();
    logic               valid;
    logic               ready;
    logic        [31:0] kernel_value;
    logic signed [31:0] gradient_x;
    logic signed [31:0] gradient_y;
    logic               in_support;
    logic               saturated;

    modport source (output valid, kernel_value, gradient_x, gradient_y, in_support,
                    saturated, input ready);
    modport sink   (input valid, kernel_value, gradient_x, gradient_y, in_support,
                    saturated, output ready);
endinterface

/* rtl/sphck_div.sv */
// Pipelined restoring divider, one quotient bit per stage, sideband carried along.
module sphck_div #(
    parameter int DEN_W  = 16,
    parameter int QUO_W  = 31,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DEN_W-1:0]  i_rem,   // upper dividend part, must be below i_den
    input  logic [QUO_W-1:0]  i_low,   // lower dividend bits, MSB first
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [QUO_W];
    logic [DEN_W-1:0]  r_rem  [QUO_W];
    logic [QUO_W-1:0]  r_bits [QUO_W];   // dividend bits out, quotient bits in
    logic [DEN_W-1:0]  r_den  [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic              c_vld;
        logic [DEN_W-1:0]  c_rem;
        logic [QUO_W-1:0]  c_bits;
        logic [DEN_W-1:0]  c_den;
        logic [SIDE_W-1:0] c_side;
        logic [DEN_W:0]    c_trial;
        logic [DEN_W:0]    c_diff;
        logic              c_ge;

        if (k == 0) begin : g_first
            assign c_vld  = i_valid;
            assign c_rem  = i_rem;
            assign c_bits = i_low;
            assign c_den  = i_den;
            assign c_side = i_side;
        end else begin : g_next
            assign c_vld  = r_vld[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_bits = r_bits[k-1];
            assign c_den  = r_den[k-1];
            assign c_side = r_side[k-1];
        end

        assign c_trial = {c_rem, c_bits[QUO_W-1]};
        assign c_diff  = c_trial - {1'b0, c_den};
        assign c_ge    = (c_trial >= {1'b0, c_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= c_ge ? c_diff[DEN_W-1:0] : c_trial[DEN_W-1:0];
                r_bits[k] <= {c_bits[QUO_W-2:0], c_ge};
                r_den[k]  <= c_den;
                r_side[k] <= c_side;
            end
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_quot  = r_bits[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

/* rtl/sph_cubic_spline_kernel_2d.sv */
// Top level: 2D cubic spline SPH kernel value and gradient, fully pipelined.
//
// Each input transaction carries a pair distance r (unsigned) and offsets dx, dy
// (signed), all with FRAC_BITS fraction bits. The block returns W = a*f(r/h) and
// grad W = a*g(r/h)/h^2 * (dx, dy) with a = 15/(7*pi*h^2), as Q16.16 values that
// clamp on overflow (saturated flags a clamp). Pairs at or beyond 2h, or with h
// equal to zero, return all zeros with in_support low; r = 0 gives a zero
// gradient. h sits in the APB register at byte address 0 (Q4.12, reset 1.0); the
// user must write it only while the block holds no transaction, as the block
// itself does not enforce this. One pair is accepted every clock while the skid
// register is empty. Each result passes through three bit-per-stage divider
// pipelines in series (r/h: 31 stages, the gradient term over R: 30, the final
// scalings by h^2 and h^4: 32, three in parallel) plus seven arithmetic stages.
// A two-entry output (result register plus skid register) keeps accepting input
// in the cycle in which the output stalls, after which the whole pipeline holds.
module sph_cubic_spline_kernel_2d #(
    parameter int FRAC_BITS   = 12,
    parameter int COORD_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sphck_in_if.sink                          i_pair,
    sphck_out_if.source                       o_kern,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sphck_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int CW      = COORD_WIDTH;
    localparam int KW      = 2 * FRAC_BITS - 14;   // kernel scale exponent
    localparam int KG      = 3 * FRAC_BITS - 14;   // gradient scale exponent
    localparam int TAG_W   = 2 * CW + 5;           // {ax, ay, nx, ny, supp, reg1, rz}
    localparam int PW      = 31 + CW;              // mg * |d|
    localparam int NWW     = 30 + KW;
    localparam int NGW     = PW + KG;
    localparam int CMP_W   = (NGW > 64) ? NGW : 64;
    localparam int GSIDE_W = TAG_W + 62;

    // tag bit positions
    localparam int T_RZ   = 0;
    localparam int T_REG1 = 1;
    localparam int T_SUPP = 2;
    localparam int T_NY   = 3;
    localparam int T_NX   = 4;
    localparam int T_AY   = 5;
    localparam int T_AX   = 5 + CW;

    // ---------------------------------------------------------------- config
    logic [15:0] r_h;
    logic [31:0] r_h2;
    logic [63:0] r_h4;
    logic        c_wr;

    assign c_wr   = psel && penable && pwrite && (paddr[2:2] == sphck_pkg::REG_SMOOTH_LEN);
    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == sphck_pkg::REG_SMOOTH_LEN) ? {16'd0, r_h} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= sphck_pkg::H_RESET;
        end else if (c_wr) begin
            r_h <= pwdata[15:0];
        end
    end

    // h^2 and h^4 are registered in turn from h, long before any pair needs them
    always_ff @(posedge i_clk) begin
        r_h2 <= 32'(r_h) * 32'(r_h);
        r_h4 <= 64'(r_h2) * 64'(r_h2);
    end

    // ---------------------------------------------------------- flow control
    // Whole pipeline advances unless the skid register is holding a result.
    logic                r_p_v;
    sphck_pkg::t_result  r_p;
    logic                r_s_v;
    sphck_pkg::t_result  r_s;
    logic                c_en;

    assign c_en         = !r_s_v;
    assign i_pair.ready = c_en;

    // ----------------------------------------------------- input, R = r / h
    logic [CW-1:0]    c_r, c_ox, c_oy, c_ax, c_ay;
    logic             c_nx, c_ny, c_supp, c_reg1, c_rz;
    logic [16:0]      c_r17;
    logic [TAG_W-1:0] c_tag;

    assign c_r    = i_pair.distance;
    assign c_ox   = i_pair.offset_x;
    assign c_oy   = i_pair.offset_y;
    assign c_nx   = c_ox[CW-1];
    assign c_ny   = c_oy[CW-1];
    assign c_ax   = c_nx ? CW'(~c_ox + CW'(1)) : c_ox;
    assign c_ay   = c_ny ? CW'(~c_oy + CW'(1)) : c_oy;
    assign c_supp = (r_h != 16'd0) && (33'(c_r) < 33'({r_h, 1'b0}));
    assign c_reg1 = (33'(c_r) < 33'(r_h));
    assign c_rz   = (c_r == '0);
    // inside support r < 2^17, so r >> 1 < h is a valid start remainder
    assign c_r17  = 17'(c_r);
    assign c_tag  = {c_ax, c_ay, c_nx, c_ny, c_supp, c_reg1, c_rz};

    logic             dR_v;
    logic [30:0]      dR_q;
    logic [TAG_W-1:0] dR_tag;

    sphck_div #(.DEN_W(16), .QUO_W(31), .SIDE_W(TAG_W)) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (i_pair.valid),
        .i_rem   (c_r17[16:1]),
        .i_low   ({c_r17[0], 30'd0}),
        .i_den   (r_h),
        .i_side  (c_tag),
        .o_valid (dR_v),
        .o_quot  (dR_q),
        .o_side  (dR_tag)
    );

    // ------------------------------------------ stage A: R^2 or (2-R)^2
    logic [30:0] c_qa, c_base;
    logic [61:0] c_sq;
    logic [32:0] c_r3;
    logic [31:0] c_gm1;

    assign c_qa   = 31'(sphck_pkg::TWO_Q30 - 32'(dR_q));
    assign c_base = dR_tag[T_REG1] ? dR_q : c_qa;
    assign c_sq   = 62'(c_base) * 62'(c_base);
    assign c_r3   = 33'({dR_q, 1'b0}) + 33'(dR_q);
    assign c_gm1  = 32'(33'(sphck_pkg::TWO_Q30) - (c_r3 >> 1));   // 2 - 1.5R

    logic             rA_v;
    logic [30:0]      rA_s, rA_base, rA_R;
    logic [31:0]      rA_gm1;
    logic [TAG_W-1:0] rA_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_v <= 1'b0;
        end else if (c_en) begin
            rA_v <= dR_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            rA_s    <= 31'(c_sq >> 30);
            rA_base <= c_base;
            rA_R    <= dR_q;
            rA_gm1  <= c_gm1;
            rA_tag  <= dR_tag;
        end
    end

    // ------------------------------------------------ stage B: cube term
    logic [61:0] c_cu;

    assign c_cu = 62'(rA_s) * 62'(rA_base);

    logic             rB_v;
    logic [30:0]      rB_cube, rB_s, rB_R;
    logic [31:0]      rB_gm1;
    logic [TAG_W-1:0] rB_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rB_v <= 1'b0;
        end else if (c_en) begin
            rB_v <= rA_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            rB_cube <= 31'(c_cu >> 30);
            rB_s    <= rA_s;
            rB_R    <= rA_R;
            rB_gm1  <= rA_gm1;
            rB_tag  <= rA_tag;
        end
    end

    // --------------------------- stage C: inner polynomial, (2-R)^3 / 6
    logic [30:0] c_pos;
    logic [29:0] c_f1;
    logic [61:0] c_p6;

    assign c_pos = 31'(rB_cube >> 1) + 31'(sphck_pkg::TWO_THIRDS_Q30);
    assign c_f1  = (c_pos > rB_s) ? 30'(c_pos - rB_s) : 30'd0;
    // x/6 = (x/2)/3 by reciprocal, exact for x/2 below 2^32
    assign c_p6  = 62'(rB_cube >> 1) * 62'(sphck_pkg::RECIP3_Q33);

    logic             rC_v;
    logic [29:0]      rC_f1, rC_f2;
    logic [30:0]      rC_s, rC_R;
    logic [31:0]      rC_gm1;
    logic [TAG_W-1:0] rC_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rC_v <= 1'b0;
        end else if (c_en) begin
            rC_v <= rB_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            rC_f1  <= c_f1;
            rC_f2  <= 30'(c_p6 >> 33);
            rC_s   <= rB_s;
            rC_R   <= rB_R;
            rC_gm1 <= rB_gm1;
            rC_tag <= rB_tag;
        end
    end

    // ------------------------------------------- stage D: m = alpha * f
    logic [29:0] c_f;
    logic [61:0] c_m;

    assign c_f = rC_tag[T_REG1] ? rC_f1 : rC_f2;
    assign c_m = 62'(sphck_pkg::ALPHA_Q32) * 62'(c_f);

    logic             rD_v;
    logic [29:0]      rD_m;
    logic [30:0]      rD_s, rD_R;
    logic [31:0]      rD_gm1;
    logic [TAG_W-1:0] rD_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rD_v <= 1'b0;
        end else if (c_en) begin
            rD_v <= rC_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            rD_m   <= 30'(c_m >> 32);
            rD_s   <= rC_s;
            rD_R   <= rC_R;
            rD_gm1 <= rC_gm1;
            rD_tag <= rC_tag;
        end
    end

    // --------------- outer region gradient: ((2-R)^2 / 2) * 2^30 / R
    // Only meaningful for R >= 1, where the start remainder is below R.
    logic               dG_v;
    logic [29:0]        dG_q;
    logic [GSIDE_W-1:0] dG_side;
    logic [TAG_W-1:0]   dG_tag;
    logic [29:0]        dG_m;
    logic [31:0]        dG_gm1;

    sphck_div #(.DEN_W(31), .QUO_W(30), .SIDE_W(GSIDE_W)) u_div_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (rD_v),
        .i_rem   (31'(rD_s >> 1)),
        .i_low   (30'd0),
        .i_den   (rD_R),
        .i_side  ({rD_tag, rD_m, rD_gm1}),
        .o_valid (dG_v),
        .o_quot  (dG_q),
        .o_side  (dG_side)
    );

    assign {dG_tag, dG_m, dG_gm1} = dG_side;

    // ----------------------------------------- stage E: mg = alpha * |g|
    logic [31:0] c_gm;
    logic [63:0] c_mg;

    assign c_gm = dG_tag[T_REG1] ? dG_gm1 : 32'(dG_q);
    assign c_mg = 64'(sphck_pkg::ALPHA_Q32) * 64'(c_gm);

    logic             rE_v;
    logic [30:0]      rE_mg;
    logic [29:0]      rE_m;
    logic [TAG_W-1:0] rE_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rE_v <= 1'b0;
        end else if (c_en) begin
            rE_v <= dG_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            rE_mg  <= 31'(c_mg >> 32);
            rE_m   <= dG_m;
            rE_tag <= dG_tag;
        end
    end

    // ----------------------------------- stage F: mg * |dx|, mg * |dy|
    logic [PW-1:0] c_px, c_py;

    assign c_px = PW'(rE_mg) * PW'(rE_tag[T_AX +: CW]);
    assign c_py = PW'(rE_mg) * PW'(rE_tag[T_AY +: CW]);

    logic          rF_v;
    logic [PW-1:0] rF_px, rF_py;
    logic [29:0]   rF_m;
    logic          rF_nx, rF_ny, rF_supp, rF_zx, rF_zy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rF_v <= 1'b0;
        end else if (c_en) begin
            rF_v <= rE_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            rF_px   <= c_px;
            rF_py   <= c_py;
            rF_m    <= rE_m;
            rF_nx   <= rE_tag[T_NX];
            rF_ny   <= rE_tag[T_NY];
            rF_supp <= rE_tag[T_SUPP];
            rF_zx   <= rE_tag[T_RZ] || (rE_tag[T_AX +: CW] == '0);
            rF_zy   <= rE_tag[T_RZ] || (rE_tag[T_AY +: CW] == '0);
        end
    end

    // --------------------- final scalings: m*2^KW / h^2, p*2^KG / h^4
    // A quotient of 2^32 or more is flagged up front and clamped later.
    logic [NWW-1:0] c_nw;
    logic [63:0]    c_nw_hi;
    logic           c_wovf;
    logic [NGW-1:0] c_ngx, c_ngy;
    logic [CMP_W-1:0] c_gx_hi, c_gy_hi;
    logic           c_xovf, c_yovf;

    assign c_nw    = {rF_m, {KW{1'b0}}};
    assign c_nw_hi = 64'(c_nw >> 32);
    assign c_wovf  = (c_nw_hi >= 64'(r_h2));
    assign c_ngx   = {rF_px, {KG{1'b0}}};
    assign c_ngy   = {rF_py, {KG{1'b0}}};
    assign c_gx_hi = CMP_W'(c_ngx >> 32);
    assign c_gy_hi = CMP_W'(c_ngy >> 32);
    assign c_xovf  = (c_gx_hi >= CMP_W'(r_h4));
    assign c_yovf  = (c_gy_hi >= CMP_W'(r_h4));

    logic        dW_v;
    logic [31:0] dW_q, dX_q, dY_q;
    logic [1:0]  dW_side;
    logic [2:0]  dX_side, dY_side;

    sphck_div #(.DEN_W(32), .QUO_W(32), .SIDE_W(2)) u_div_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (rF_v),
        .i_rem   (32'(c_nw >> 32)),
        .i_low   (c_nw[31:0]),
        .i_den   (r_h2),
        .i_side  ({rF_supp, c_wovf}),
        .o_valid (dW_v),
        .o_quot  (dW_q),
        .o_side  (dW_side)
    );

    // gradient sign is opposite to the offset sign
    sphck_div #(.DEN_W(64), .QUO_W(32), .SIDE_W(3)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (rF_v),
        .i_rem   (64'(c_ngx >> 32)),
        .i_low   (c_ngx[31:0]),
        .i_den   (r_h4),
        .i_side  ({c_xovf, !rF_nx, rF_zx}),
        .o_valid (),
        .o_quot  (dX_q),
        .o_side  (dX_side)
    );

    sphck_div #(.DEN_W(64), .QUO_W(32), .SIDE_W(3)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (rF_v),
        .i_rem   (64'(c_ngy >> 32)),
        .i_low   (c_ngy[31:0]),
        .i_den   (r_h4),
        .i_side  ({c_yovf, !rF_ny, rF_zy}),
        .o_valid (),
        .o_quot  (dY_q),
        .o_side  (dY_side)
    );

    // ------------------------------------ stage G: clamp and support mask
    sphck_pkg::t_grad   c_gx, c_gy;
    sphck_pkg::t_result c_res;

    always_comb begin
        c_gx  = sphck_pkg::sat_grad(dX_q, dX_side[2], dX_side[1], dX_side[0]);
        c_gy  = sphck_pkg::sat_grad(dY_q, dY_side[2], dY_side[1], dY_side[0]);
        c_res = '0;
        if (dW_side[1]) begin
            c_res.kernel_value = dW_side[0] ? 32'hFFFF_FFFF : dW_q;
            c_res.gradient_x   = c_gx.value;
            c_res.gradient_y   = c_gy.value;
            c_res.in_support   = 1'b1;
            c_res.saturated    = dW_side[0] || c_gx.sat || c_gy.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (c_en) begin
            r_p_v <= dW_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_p <= c_res;
        end
    end

    // -------------------------------------------------- output skid stage
    // Catches the result register's transaction when the sink stalls while
    // the pipeline is still moving; drains first once the sink is ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (r_s_v) begin
            if (o_kern.ready) begin
                r_s_v <= 1'b0;
            end
        end else if (r_p_v && !o_kern.ready) begin
            r_s_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_s_v) begin
            r_s <= r_p;
        end
    end

    sphck_pkg::t_result c_out;

    assign c_out               = r_s_v ? r_s : r_p;
    assign o_kern.valid        = r_s_v || r_p_v;
    assign o_kern.kernel_value = c_out.kernel_value;
    assign o_kern.gradient_x   = c_out.gradient_x;
    assign o_kern.gradient_y   = c_out.gradient_y;
    assign o_kern.in_support   = c_out.in_support;
    assign o_kern.saturated    = c_out.saturated;

    // ------------------------------------------------------------ checks
    a_out_of_support_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_kern.valid && !o_kern.in_support |->
            o_kern.kernel_value == 32'd0 && o_kern.gradient_x == 32'sd0 &&
            o_kern.gradient_y == 32'sd0 && !o_kern.saturated)
        else $error("nonzero result outside support");

    a_sat_in_support: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_kern.valid && o_kern.saturated |-> o_kern.in_support)
        else $error("saturation flagged outside support");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_kern.valid && !o_kern.ready |=> o_kern.valid && $stable(c_out))
        else $error("output transaction changed while stalled");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v && o_kern.ready |=> !r_s_v)
        else $error("skid register did not drain");

endmodule
